// File: rtl/assert_macros.svh
// assertion macros used by bcospi_checker.sv
// needs clk and rst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define BC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define BC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// expression holds at every edge out of reset
`define BC_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

`endif

// File: rtl/bcospi_pkg.sv
// package for the bfloat16 cos(pi*x) pipeline
// constants, coefficient rounding and the stage sideband type; no dependencies
package bcospi_pkg;

    localparam int DEF_POLY_FRAC_BITS = 40;
    localparam int HORNER_STEPS       = 3;
    localparam int PIPE_DEPTH         = 2 + 3 * HORNER_STEPS + 3;

    localparam int K_W  = 12;
    localparam int SQ_W = 2 * K_W;

    localparam logic [15:0] RES_INF   = 16'h7FFF;
    localparam logic [15:0] RES_ONE   = 16'h3F80;
    localparam logic [14:0] MAG_INF   = 15'h7F80;
    localparam logic [14:0] MAG_ONE   = 15'h3F80;
    localparam logic [7:0]  EXP_LO    = 8'd121;
    localparam logic [7:0]  EXP_HI    = 8'd135;
    localparam logic [12:0] K_ONE_MAX = 13'd163;
    localparam logic [12:0] K_HALF    = 13'd4096;
    localparam logic [13:0] K_PERIOD  = 14'd8192;

    // coefficients scaled by 2^60
    localparam logic signed [63:0] COEF_C4 = -64'sd1342019967204940032;
    localparam logic signed [63:0] COEF_C3 = 64'sd4636485307015996416;
    localparam logic signed [63:0] COEF_C2 = -64'sd5686762499100653568;
    localparam logic signed [63:0] COEF_C1 = 64'sd1152898409967004800;

    localparam logic signed [63:0] HORNER_COEF [0:HORNER_STEPS-1] =
        '{COEF_C3, COEF_C2, COEF_C1};

    typedef struct packed {
        logic            spec;
        logic [15:0]     sres;
        logic            flip;
        logic [SQ_W-1:0] s;
    } side_t;

    // magnitude of a 2^60 coefficient rounded to frac_bits, halves away from zero
    function automatic logic [63:0] coef_mag(input logic signed [63:0] c,
                                             input int frac_bits);
        logic [63:0] m;
        int          n;
        m = c[63] ? 64'(-c) : 64'(c);
        n = 60 - frac_bits;
        if (n > 0)
        begin
            m = (m + (64'd1 << (n - 1))) >> n;
        end
        return m;
    endfunction

    function automatic logic [63:0] coef_signed(input logic signed [63:0] c,
                                                input int frac_bits);
        logic [63:0] m;
        m = coef_mag(c, frac_bits);
        return c[63] ? (64'd0 - m) : m;
    endfunction

endpackage

// File: rtl/bfloat16_cospi_top.sv
// bfloat16 cos(pi*x) unit, fully pipelined
// depends on bcospi_pkg

// Takes one bfloat16 operand per cycle while the output is not held off and
// returns one bfloat16 result per request, in order. The depth comes from
// decode, squaring of the fraction, three Horner steps of the degree-3
// polynomial in x^2 (each a split multiply stage, a round-and-add stage and a
// magnitude stage) and a three-stage normalise and round to nearest even.
// Every stage has its own valid bit and advances when the stage after it is
// empty or moving, so bubbles close up under back pressure and in_ready stays
// high whenever out_ready is high. NaN passes through, infinities give 0x7FFF
// and |x| of 256 or more gives 1.0.
module bfloat16_cospi_top #(
    parameter int POLY_FRAC_BITS = bcospi_pkg::DEF_POLY_FRAC_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] x_bits,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] result_bits
);

    localparam int NST  = bcospi_pkg::PIPE_DEPTH;
    localparam int NHS  = bcospi_pkg::HORNER_STEPS;
    localparam int SQW  = bcospi_pkg::SQ_W;
    localparam int MW   = POLY_FRAC_BITS + 3;
    localparam int YW   = MW + 1;
    localparam int HW   = MW - 32;
    localparam int PLW  = 32 + SQW;
    localparam int PHW  = HW + SQW;
    localparam int PW   = MW + SQW;
    localparam int PBW  = $clog2(MW);
    localparam logic [MW-1:0] C4_MAG =
        MW'(bcospi_pkg::coef_mag(bcospi_pkg::COEF_C4, POLY_FRAC_BITS));
    localparam logic          C4_NEG = bcospi_pkg::COEF_C4[63];
    localparam logic [PW-1:0] RND_HALF = PW'(1) << 25;
    localparam logic [9:0]    EXP_OFF  = 10'(127 - POLY_FRAC_BITS);
    localparam logic [PBW-1:0] TOP_POS = PBW'(MW - 1);

    logic [NST-1:0]     v_reg;
    logic [NST-1:0]     v_next;
    logic [NST-1:0]     en;
    bcospi_pkg::side_t  side_reg  [0:NST-2];
    bcospi_pkg::side_t  side_next [0:NST-2];
    bcospi_pkg::side_t  side_dec;

    // decode
    logic [14:0]  dmag;
    logic [7:0]   dexp;
    logic [3:0]   dsh;
    logic [20:0]  da;
    logic [12:0]  dk0;
    logic [12:0]  dkk;
    logic         dflip;

    // horner
    logic [PLW-1:0]        pl_reg   [0:NHS-1];
    logic [PHW-1:0]        ph_reg   [0:NHS-1];
    logic                  msg_reg  [0:NHS-1];
    logic signed [YW-1:0]  y_reg    [0:NHS-1];
    logic [MW-1:0]         mag_reg  [0:NHS-1];
    logic                  sg_reg   [0:NHS-1];
    logic [PLW-1:0]        pl_next  [0:NHS-1];
    logic [PHW-1:0]        ph_next  [0:NHS-1];
    logic                  msg_next [0:NHS-1];
    logic signed [YW-1:0]  y_next   [0:NHS-1];
    logic [MW-1:0]         mag_next [0:NHS-1];
    logic                  sg_next  [0:NHS-1];

    // normalise and round
    logic [MW-1:0]  u_reg;
    logic [PBW-1:0] p_reg;
    logic           z_reg;
    logic [PBW-1:0] p_next;
    logic           z_next;
    logic [MW-1:0]  nv;
    logic [7:0]     mant_reg;
    logic           inc_reg;
    logic [PBW-1:0] p2_reg;
    logic           z2_reg;
    logic [7:0]     mant_next;
    logic           inc_next;
    logic [8:0]     m9;
    logic [9:0]     bexp;
    logic [15:0]    result_reg;
    logic [15:0]    result_next;

    // stage enables: a stage loads when it is empty or its successor loads
    always_comb
    begin
        en[NST-1] = !v_reg[NST-1] || out_ready;
        for (int i = NST - 2; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
        v_next[0] = in_valid;
        for (int i = 1; i < NST; i++)
        begin
            v_next[i] = v_reg[i-1];
        end
    end

    assign in_ready    = en[0];
    assign out_valid   = v_reg[NST-1];
    assign result_bits = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NST; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= v_next[i];
                end
            end
        end
    end

    // stage 0: classify, split |x| into integer parity and fraction
    always_comb
    begin
        dmag  = x_bits[14:0];
        dexp  = dmag[14:7];
        dsh   = 4'(dexp - bcospi_pkg::EXP_LO);
        da    = 21'({1'b1, x_bits[6:0]}) << dsh;
        dk0   = da[12:0];
        dflip = da[13];
        dkk   = dk0;
        if (dk0 >= bcospi_pkg::K_HALF)
        begin
            dkk   = 13'(bcospi_pkg::K_PERIOD - 14'(dk0));
            dflip = ~dflip;
        end
        side_dec.spec = 1'b1;
        side_dec.flip = dflip;
        side_dec.s    = SQW'(dkk[11:0]);
        if (dmag > bcospi_pkg::MAG_INF)
        begin
            side_dec.sres = x_bits;
        end
        else if (dmag == bcospi_pkg::MAG_INF)
        begin
            side_dec.sres = bcospi_pkg::RES_INF;
        end
        else if (dexp >= bcospi_pkg::EXP_HI || dexp < bcospi_pkg::EXP_LO)
        begin
            side_dec.sres = bcospi_pkg::RES_ONE;
        end
        else if (dkk <= bcospi_pkg::K_ONE_MAX)
        begin
            side_dec.sres = {dflip, bcospi_pkg::MAG_ONE};
        end
        else if (dkk == bcospi_pkg::K_HALF)
        begin
            side_dec.sres = {dflip, 15'd0};
        end
        else
        begin
            side_dec.spec = 1'b0;
            side_dec.sres = '0;
        end
    end

    // sideband through the remaining stages
    always_comb
    begin
        side_next[0] = side_dec;
        for (int i = 1; i < NST - 1; i++)
        begin
            side_next[i] = side_reg[i-1];
        end
        // stage 1: square of the fraction in units of 2^-13
        side_next[1].s = SQW'(side_reg[0].s[bcospi_pkg::K_W-1:0])
                       * SQW'(side_reg[0].s[bcospi_pkg::K_W-1:0]);
        // from the leading-one stage on, flip is the result sign
        side_next[NST-3].flip = side_reg[NST-4].flip ^ sg_reg[NHS-1];
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NST - 1; i++)
        begin
            if (en[i])
            begin
                side_reg[i] <= side_next[i];
            end
        end
    end

    // horner steps: y = y * x^2 + c, three stages each
    for (genvar j = 0; j < NHS; j++)
    begin : g_horner
        localparam int SM = 2 + 3 * j;
        localparam logic signed [YW-1:0] CY =
            YW'(bcospi_pkg::coef_signed(bcospi_pkg::HORNER_COEF[j], POLY_FRAC_BITS));

        logic [MW-1:0]        src_mag;
        logic                 src_neg;
        logic [PW-1:0]        prod;
        logic [MW-3:0]        rnd;
        logic signed [YW-1:0] rext;
        logic signed [YW-1:0] yabs;

        if (j == 0)
        begin : g_first
            assign src_mag = C4_MAG;
            assign src_neg = C4_NEG;
        end
        else
        begin : g_rest
            assign src_mag = mag_reg[j-1];
            assign src_neg = sg_reg[j-1];
        end

        always_comb
        begin
            pl_next[j]  = PLW'(src_mag[31:0]) * PLW'(side_reg[SM-1].s);
            ph_next[j]  = PHW'(src_mag[MW-1:32]) * PHW'(side_reg[SM-1].s);
            msg_next[j] = src_neg;

            prod      = {ph_reg[j], 32'd0} + PW'(pl_reg[j]) + RND_HALF;
            rnd       = prod[PW-1:26];
            rext      = YW'({3'b000, rnd});
            y_next[j] = (msg_reg[j] ? -rext : rext) + CY;

            sg_next[j]  = y_reg[j][YW-1];
            yabs        = sg_next[j] ? -y_reg[j] : y_reg[j];
            mag_next[j] = yabs[MW-1:0];
        end

        always_ff @(posedge clk)
        begin
            if (en[SM])
            begin
                pl_reg[j]  <= pl_next[j];
                ph_reg[j]  <= ph_next[j];
                msg_reg[j] <= msg_next[j];
            end
            if (en[SM+1])
            begin
                y_reg[j] <= y_next[j];
            end
            if (en[SM+2])
            begin
                mag_reg[j] <= mag_next[j];
                sg_reg[j]  <= sg_next[j];
            end
        end
    end

    // leading one position
    always_comb
    begin
        p_next = '0;
        for (int i = 0; i < MW; i++)
        begin
            if (mag_reg[NHS-1][i])
            begin
                p_next = PBW'(i);
            end
        end
        z_next = ~|mag_reg[NHS-1];
    end

    // normalise, take 8 bits plus guard and sticky
    always_comb
    begin
        nv        = u_reg << (TOP_POS - p_reg);
        mant_next = nv[MW-1:MW-8];
        inc_next  = nv[MW-9] & ((|nv[MW-10:0]) | nv[MW-8]);
    end

    // round and pack
    always_comb
    begin
        m9   = {1'b0, mant_reg} + 9'(inc_reg);
        bexp = 10'(p2_reg) + 10'(m9[8]) + EXP_OFF;
        if (side_reg[NST-2].spec)
        begin
            result_next = side_reg[NST-2].sres;
        end
        else if (z2_reg)
        begin
            result_next = {side_reg[NST-2].flip, 15'd0};
        end
        else
        begin
            result_next = {side_reg[NST-2].flip, bexp[7:0], m9[6:0]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[NST-3])
        begin
            u_reg <= mag_reg[NHS-1];
            p_reg <= p_next;
            z_reg <= z_next;
        end
        if (en[NST-2])
        begin
            mant_reg <= mant_next;
            inc_reg  <= inc_next;
            p2_reg   <= p_reg;
            z2_reg   <= z_reg;
        end
        if (en[NST-1])
        begin
            result_reg <= result_next;
        end
    end

endmodule

// File: rtl/bcospi_checker.sv
// port-level checker for bfloat16_cospi_top, bound to the top level
// depends on bcospi_pkg and assert_macros.svh
`include "assert_macros.svh"

module bcospi_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [15:0] x_bits,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] result_bits
);

    logic [4:0] pend_reg;
    logic [4:0] pend_next;
    logic       in_acc;
    logic       out_acc;

    assign in_acc    = in_valid && in_ready;
    assign out_acc   = out_valid && out_ready;
    assign pend_next = pend_reg + 5'(in_acc) - 5'(out_acc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    `BC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(result_bits), "result dropped or changed while stalled")
    `BC_ASSERT_SAME(a_flow, out_ready, in_ready, "request refused while output drains")
    `BC_ASSERT_SAME(a_no_phantom, out_valid, pend_reg != 5'd0, "result with no request outstanding")
    `BC_ASSERT_ALWAYS(a_depth, pend_reg <= 5'(bcospi_pkg::PIPE_DEPTH), "more requests in flight than stages")

endmodule

bind bfloat16_cospi_top bcospi_checker u_bcospi_checker (.*);

// File: tb/tb.sv
// self-checking testbench for bfloat16_cospi_top: directed table then random requests
// predicts cos(pi*x) in fixed point and checks every result in order
// depends on bcospi_pkg and bfloat16_cospi_top
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PFB         = 40;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RAND_BLOCKS = 12;
    localparam int BLOCK_LEN   = 95;
    localparam int BURST_LEN   = 40;
    localparam int LONG_HOLD   = 150;
    localparam int DRAIN_WAIT  = 30;
    localparam int MAX_SHOWN   = 10;

    typedef struct packed {
        logic [15:0] x;
        logic        typed;
        logic [15:0] res;
    } dir_row_t;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] res;
    } cos_due_t;

    localparam int DIR_ROWS = 23;
    localparam dir_row_t DIR_TAB [0:DIR_ROWS-1] = '{
        '{16'h0000, 1'b1, bcospi_pkg::RES_ONE},   // zero
        '{16'h8000, 1'b1, bcospi_pkg::RES_ONE},   // negative zero
        '{16'h0001, 1'b1, bcospi_pkg::RES_ONE},   // subnormal
        '{16'h3C7F, 1'b1, bcospi_pkg::RES_ONE},   // just under 2^-6
        '{16'h3C80, 1'b1, bcospi_pkg::RES_ONE},   // 2^-6
        '{16'h3CA3, 1'b1, bcospi_pkg::RES_ONE},   // last small fraction
        '{16'h3CA4, 1'b0, 16'h0000},              // first polynomial fraction
        '{16'h7F80, 1'b1, bcospi_pkg::RES_INF},
        '{16'hFF80, 1'b1, bcospi_pkg::RES_INF},
        '{16'h7FC0, 1'b1, 16'h7FC0},              // nan passes through
        '{16'hFF81, 1'b1, 16'hFF81},
        '{16'h7FFF, 1'b1, 16'h7FFF},
        '{16'hFFFF, 1'b1, 16'hFFFF},
        '{16'h4380, 1'b1, bcospi_pkg::RES_ONE},   // 256
        '{16'hC37F, 1'b1, 16'hBF80},              // -255, odd integer
        '{16'h3F80, 1'b1, 16'hBF80},              // 1.0
        '{16'h3F00, 1'b1, 16'h8000},              // exact half
        '{16'hBFC0, 1'b1, 16'h0000},              // -1.5, half with odd integer
        '{16'h3F7F, 1'b1, 16'hBF80},              // mirrored small fraction
        '{16'h3E80, 1'b0, 16'h0000},
        '{16'hBF40, 1'b0, 16'h0000},
        '{16'h3EAB, 1'b0, 16'h0000},
        '{16'h42F7, 1'b0, 16'h0000}
    };

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [15:0] x_bits;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] result_bits;

    cos_due_t pending_cos [$];
    int       bad_count;
    int       long_hold;
    logic     calm;

    bfloat16_cospi_top #(
        .POLY_FRAC_BITS(PFB)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .x_bits     (x_bits),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result_bits(result_bits)
    );

    // coefficient held at 2^60, rounded to PFB fraction bits, halves away from zero
    function automatic logic signed [63:0] coef_fixed(input logic signed [63:0] c);
        logic [63:0] m;
        m = c[63] ? 64'd0 - c : c;
        if (PFB < 60)
        begin
            m = (m + (64'd1 << (59 - PFB))) >> (60 - PFB);
        end
        return c[63] ? 64'd0 - m : m;
    endfunction

    // y * k^2 / 2^26, magnitude rounded half up
    function automatic logic signed [63:0] mul_xsq(input logic signed [63:0] y,
                                                   input logic [31:0] s);
        logic [63:0] m;
        logic [63:0] r;
        m = y[63] ? 64'd0 - y : y;
        r = (((m >> 32) * s) << 6) + ((((m & 64'hFFFF_FFFF) * s) + (64'd1 << 25)) >> 26);
        return y[63] ? 64'd0 - r : r;
    endfunction

    function automatic logic [15:0] cospi_bf16(input logic [15:0] xb);
        logic [14:0]        mag;
        logic [7:0]         ex;
        logic [31:0]        a;
        logic [31:0]        k;
        logic [31:0]        s;
        logic               flip;
        logic               sgn;
        logic signed [63:0] y;
        logic [63:0]        u;
        logic [63:0]        rem;
        logic [63:0]        half;
        logic [63:0]        mant;
        int                 p;
        int                 sh;
        mag = xb[14:0];
        ex  = mag[14:7];
        if (mag > bcospi_pkg::MAG_INF)
            return xb;
        if (mag == bcospi_pkg::MAG_INF)
            return bcospi_pkg::RES_INF;
        if (ex >= bcospi_pkg::EXP_HI || ex < bcospi_pkg::EXP_LO)
            return bcospi_pkg::RES_ONE;
        a    = 32'({1'b1, mag[6:0]}) << (ex - bcospi_pkg::EXP_LO);
        flip = a[13];
        k    = 32'(a[12:0]);
        if (k >= 32'(bcospi_pkg::K_HALF))
        begin
            k    = 32'(bcospi_pkg::K_PERIOD) - k;
            flip = ~flip;
        end
        if (k <= 32'(bcospi_pkg::K_ONE_MAX))
            return {flip, bcospi_pkg::MAG_ONE};
        if (k >= 32'(bcospi_pkg::K_HALF))
            return {flip, 15'd0};
        s = k * k;
        y = coef_fixed(bcospi_pkg::COEF_C4);
        y = mul_xsq(y, s) + coef_fixed(bcospi_pkg::COEF_C3);
        y = mul_xsq(y, s) + coef_fixed(bcospi_pkg::COEF_C2);
        y = mul_xsq(y, s) + coef_fixed(bcospi_pkg::COEF_C1);
        sgn = flip ^ y[63];
        u   = y[63] ? 64'd0 - y : y;
        if (u == 64'd0)
            return {sgn, 15'd0};
        p = 63;
        while (!u[p])
            p--;
        if (p >= 8)
        begin
            sh   = p - 7;
            rem  = u & ((64'd1 << sh) - 64'd1);
            half = 64'd1 << (sh - 1);
            mant = u >> sh;
            if (rem > half || (rem == half && mant[0]))
                mant++;
            if (mant == 64'd256)
            begin
                mant = 64'd128;
                p++;
            end
        end
        else
        begin
            mant = u << (7 - p);
        end
        return {sgn, 8'(p - PFB + 127), mant[6:0]};
    endfunction

    function automatic logic [15:0] pick_operand();
        logic [15:0] v;
        int          sel;
        sel = $urandom_range(99);
        v   = 16'($urandom);
        if (sel < 60)
        begin
            v[14:7] = 8'($urandom_range(136, 119));
        end
        else if (sel < 70)
        begin
            // exponents 126 to 134 with the low four mantissa bits cleared
            v[14:7] = 8'($urandom_range(134, 126));
            v[3:0]  = 4'd0;
        end
        else if (sel < 76)
        begin
            v[14:0] = bcospi_pkg::MAG_INF;
        end
        else if (sel < 82)
        begin
            v[14:7] = 8'hFF;
        end
        else if (sel < 86)
        begin
            v[14:7] = 8'h00;
        end
        return v;
    endfunction

    task automatic send_req(input logic [15:0] x, input logic typed,
                            input logic [15:0] res, input int gap);
        cos_due_t due;
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        x_bits   <= x;
        do @(posedge clk); while (!in_ready);
        due.x   = x;
        due.res = typed ? res : cospi_bf16(x);
        pending_cos.push_back(due);
    endtask

    task automatic wait_drained();
        while (pending_cos.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Verification failed");
        $finish;
    end

    // receiver: random hold-offs, calm stretches and one long stall
    initial
    begin
        int w;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            w = calm ? 0 : $urandom_range(10);
            if (long_hold > 0)
            begin
                w         = long_hold;
                long_hold = 0;
            end
            if (w > 0)
            begin
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (w - 1) @(negedge clk);
            end
            @(negedge clk);
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    always @(posedge clk)
    begin
        cos_due_t due;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_cos.size() == 0)
            begin
                bad_count++;
                if (bad_count <= MAX_SHOWN)
                    $display("unexpected result %h", result_bits);
            end
            else
            begin
                due = pending_cos.pop_front();
                if (result_bits !== due.res)
                begin
                    bad_count++;
                    if (bad_count <= MAX_SHOWN)
                        $display("x %h: expected %h, got %h", due.x, due.res, result_bits);
                end
            end
        end
    end

    initial
    begin
        bad_count = 0;
        long_hold = 0;
        calm      = 1'b0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        x_bits    = 16'h0000;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
            send_req(DIR_TAB[i].x, DIR_TAB[i].typed, DIR_TAB[i].res, $urandom_range(10));

        // hold the sender until the pipe is empty
        @(negedge clk);
        in_valid <= 1'b0;
        wait_drained();

        // long output stall while requests keep coming, filling the pipe
        long_hold = LONG_HOLD;
        for (int i = 0; i < BURST_LEN; i++)
            send_req(pick_operand(), 1'b0, 16'h0000, 0);

        for (int b = 0; b < RAND_BLOCKS; b++)
        begin
            calm = ($urandom_range(3) == 0);
            for (int i = 0; i < BLOCK_LEN; i++)
                send_req(pick_operand(), 1'b0, 16'h0000, calm ? 0 : $urandom_range(10));
        end
        @(negedge clk);
        in_valid <= 1'b0;

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (bad_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/bcospi_pkg.sv
rtl/bfloat16_cospi_top.sv
rtl/bcospi_checker.sv
tb/tb.sv
